>>> sv/wass_pkg.sv
package wass_pkg;

   localparam int FUNC_W  = 1;
   localparam int SLOT_W  = 3;
   localparam int FIELD_W = 32;
   localparam int MASK_W  = 8;
   localparam int NOW_W   = 32;
   localparam int CFG_W   = 16;
   localparam int CSR_IDX_W = 1;

   localparam logic [FUNC_W-1:0] FUNC_TICK = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_LOAD = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_TICK_LEN = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW   = 1'b1;

   localparam logic [CFG_W-1:0] TICK_LEN_RESET = 16'd10;
   localparam logic [CFG_W-1:0] WINDOW_RESET   = 16'd10;

   typedef enum logic {
      AOP_ADD_SAT  = 1'b0,
      AOP_ABS_DIFF = 1'b1
   } arith_op_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_ADD   = 5'b00010,
      ST_CHECK = 5'b00100,
      ST_ADV   = 5'b01000,
      ST_FIN   = 5'b10000
   } state_type;

endpackage

>>> sv/wass_req_if.sv
interface wass_req_if import wass_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FUNC_W-1:0]  func;
   logic [SLOT_W-1:0]  slot;
   logic [FIELD_W-1:0] alarm_time;
   logic [FIELD_W-1:0] period;
   logic               repeat_req;

   modport source (output valid, func, slot, alarm_time, period, repeat_req, input ready);
   modport sink   (input valid, func, slot, alarm_time, period, repeat_req, output ready);
endinterface

>>> sv/wass_rsp_if.sv
interface wass_rsp_if import wass_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MASK_W-1:0] fire_mask;
   logic [NOW_W-1:0]  now;

   modport source (output valid, fire_mask, now, input ready);
   modport sink   (input valid, fire_mask, now, output ready);
endinterface

>>> sv/windowed_alarm_slot_scheduler_unit.sv
// Alarm slot scheduler. A tick request adds tick_len to a saturating time counter and then
// walks the slots one per cycle, but for an advance step after each slot that fires and
// repeats, through a single slot RAM and one shared adder/subtractor, firing, suspending,
// releasing and rescheduling each valid slot; the response carries the fire mask of slots
// 0..7 and the new time. A tick goes through the add step, a check step for each slot and
// the finish step, plus the advance steps (the alarm advance reuses the same adder and the
// RAM write port). A load request goes from acceptance straight to the finish step. A
// finished response waits in its output register while the next request is taken; a
// request that finishes while that register is still held waits in its finish step.
module windowed_alarm_slot_scheduler_unit import wass_pkg::*; #(
   parameter int SLOTS     = 8,
   parameter int TIME_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   wass_req_if.sink             req_chan,
   wass_rsp_if.source           rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   localparam int SIDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int RAM_W  = 2 * TIME_BITS;

   state_type             state_ff, state_in;
   logic [SIDX_W-1:0]     idx_ff, idx_in;
   logic [TIME_BITS-1:0]  time_ff, time_in;
   logic [CFG_W-1:0]      tick_len_ff, tick_len_in;
   logic [CFG_W-1:0]      window_ff, window_in;
   logic [SLOTS-1:0]      valid_ff, valid_in;
   logic [SLOTS-1:0]      susp_ff, susp_in;
   logic [SLOTS-1:0]      rep_ff, rep_in;
   logic [MASK_W-1:0]     mask_ff, mask_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [MASK_W-1:0]     rsp_mask_ff, rsp_mask_in;
   logic [NOW_W-1:0]      rsp_now_ff, rsp_now_in;

   arith_op_type          au_op;
   logic [TIME_BITS-1:0]  au_a, au_b, au_res;

   logic                  ram_wr_en, ram_rd_en;
   logic [SIDX_W-1:0]     ram_wr_addr, ram_rd_addr;
   logic [RAM_W-1:0]      ram_wr_data, ram_rd_data;
   logic [TIME_BITS-1:0]  rd_alarm, rd_period;

   logic                  req_fire;
   logic                  slot_ok;
   logic                  last;
   logic                  fire;
   logic                  release_hit;
   logic [TIME_BITS-1:0]  win_ext;

   assign rd_alarm  = ram_rd_data[RAM_W-1:TIME_BITS];
   assign rd_period = ram_rd_data[TIME_BITS-1:0];
   assign win_ext   = TIME_BITS'(window_ff);

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign slot_ok        = (32'(req_chan.slot) < 32'(SLOTS));
   assign last           = (idx_ff == SIDX_W'(SLOTS - 1));

   assign fire        = valid_ff[idx_ff] && !susp_ff[idx_ff] && (au_res < win_ext);
   assign release_hit = valid_ff[idx_ff] && susp_ff[idx_ff] && (au_res > win_ext);

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.fire_mask = rsp_mask_ff;
   assign rsp_chan.now       = rsp_now_ff;

   wass_arith #(.W(TIME_BITS)) u_arith (
      .op     (au_op),
      .a      (au_a),
      .b      (au_b),
      .result (au_res)
   );

   wass_ram #(.WIDTH(RAM_W), .DEPTH(SLOTS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      au_op = AOP_ADD_SAT;
      au_a  = rd_alarm;
      au_b  = rd_period;
      case (state_ff)
         ST_ADD: begin
            au_op = AOP_ADD_SAT;
            au_a  = time_ff;
            au_b  = TIME_BITS'(tick_len_ff);
         end
         ST_CHECK: begin
            au_op = AOP_ABS_DIFF;
            au_a  = time_ff;
            au_b  = rd_alarm;
         end
         default: begin
            au_op = AOP_ADD_SAT;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      time_in      = time_ff;
      tick_len_in  = tick_len_ff;
      window_in    = window_ff;
      valid_in     = valid_ff;
      susp_in      = susp_ff;
      rep_in       = rep_ff;
      mask_in      = mask_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_mask_in  = rsp_mask_ff;
      rsp_now_in   = rsp_now_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = idx_ff;
      ram_wr_data  = {au_res, rd_period};
      ram_rd_en    = 1'b0;
      ram_rd_addr  = idx_ff + SIDX_W'(1);

      if (csr_we) begin
         case (csr_index)
            CSR_TICK_LEN: tick_len_in = csr_wdata;
            CSR_WINDOW:   window_in   = csr_wdata;
            default:      tick_len_in = tick_len_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               mask_in = '0;
               if (req_chan.func == FUNC_LOAD) begin
                  state_in = ST_FIN;
                  if (slot_ok) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = SIDX_W'(req_chan.slot);
                     ram_wr_data = {TIME_BITS'(req_chan.alarm_time),
                                    TIME_BITS'(req_chan.period)};
                     valid_in[SIDX_W'(req_chan.slot)] = 1'b1;
                     susp_in[SIDX_W'(req_chan.slot)]  = 1'b0;
                     rep_in[SIDX_W'(req_chan.slot)]   = req_chan.repeat_req;
                  end
               end else begin
                  state_in = ST_ADD;
               end
            end
         end
         ST_ADD: begin
            time_in     = au_res;
            idx_in      = '0;
            ram_rd_en   = 1'b1;
            ram_rd_addr = '0;
            state_in    = ST_CHECK;
         end
         ST_CHECK: begin
            if (fire) begin
               susp_in[idx_ff] = 1'b1;
               for (int i = 0; i < MASK_W; i++) begin
                  if ((i < SLOTS) && (idx_ff == SIDX_W'(i))) begin
                     mask_in[i] = 1'b1;
                  end
               end
            end else if (release_hit) begin
               susp_in[idx_ff] = 1'b0;
            end
            if (fire && rep_ff[idx_ff]) begin
               state_in = ST_ADV;
            end else if (last) begin
               state_in = ST_FIN;
            end else begin
               ram_rd_en = 1'b1;
               idx_in    = idx_ff + SIDX_W'(1);
            end
         end
         ST_ADV: begin
            ram_wr_en = 1'b1;
            if (last) begin
               state_in = ST_FIN;
            end else begin
               ram_rd_en = 1'b1;
               idx_in    = idx_ff + SIDX_W'(1);
               state_in  = ST_CHECK;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_mask_in  = mask_ff;
               rsp_now_in   = NOW_W'(time_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         time_ff      <= '0;
         tick_len_ff  <= TICK_LEN_RESET;
         window_ff    <= WINDOW_RESET;
         valid_ff     <= '0;
         susp_ff      <= '0;
         rep_ff       <= '0;
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         time_ff      <= time_in;
         tick_len_ff  <= tick_len_in;
         window_ff    <= window_in;
         valid_ff     <= valid_in;
         susp_ff      <= susp_in;
         rep_ff       <= rep_in;
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_mask_ff <= rsp_mask_in;
      rsp_now_ff  <= rsp_now_in;
   end

`ifndef SYNTHESIS
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("response raised outside the finish step");

   a_load_keeps_time: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.func == FUNC_LOAD) |=> (state_ff == ST_FIN) && $stable(time_ff))
      else $error("load request disturbed the time counter");

   a_time_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (time_ff >= $past(time_ff)))
      else $error("time counter went backward");

   a_susp_needs_valid: assert property (@(posedge clock) disable iff (reset)
      (susp_ff & ~valid_ff) == '0)
      else $error("suspended slot is not valid");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK || state_ff == ST_ADV) |-> (32'(idx_ff) < 32'(SLOTS)))
      else $error("slot walk index out of range");
`endif

endmodule

>>> sv/wass_ram.sv
module wass_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/wass_arith.sv
module wass_arith import wass_pkg::*; #(
   parameter int W = 32
) (
   input  arith_op_type op,
   input  logic [W-1:0] a,
   input  logic [W-1:0] b,
   output logic [W-1:0] result
);

   logic [W:0]   sum;
   logic         a_ge_b;
   logic [W-1:0] diff;

   always_comb begin
      sum    = {1'b0, a} + {1'b0, b};
      a_ge_b = (a >= b);
      diff   = a_ge_b ? (a - b) : (b - a);
      case (op)
         AOP_ADD_SAT:  result = sum[W] ? {W{1'b1}} : sum[W-1:0];
         AOP_ABS_DIFF: result = diff;
         default:      result = sum[W-1:0];
      endcase
   end

endmodule

>>> sim/windowed_alarm_slot_scheduler_unit_test.sv
`timescale 1ns / 1ps

module windowed_alarm_slot_scheduler_unit_test import wass_pkg::*; ();

   localparam int SLOT_COUNT  = 8;
   localparam int STALL_LIMIT = 4000;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [SLOT_W-1:0]  slot;
      logic [FIELD_W-1:0] alarm_time;
      logic [FIELD_W-1:0] period;
      logic               repeat_req;
   } sched_req_type;

   typedef struct packed {
      logic [MASK_W-1:0] fire_mask;
      logic [NOW_W-1:0]  now;
   } sched_rsp_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   wass_req_if req_bus();
   wass_rsp_if rsp_bus();

   windowed_alarm_slot_scheduler_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic [CFG_W-1:0]   tick_len_cfg = TICK_LEN_RESET;
   logic [CFG_W-1:0]   window_cfg   = WINDOW_RESET;
   logic [NOW_W-1:0]   clock_now    = '0;
   logic [FIELD_W-1:0] alarm_tab  [SLOT_COUNT] = '{default: '0};
   logic [FIELD_W-1:0] period_tab [SLOT_COUNT] = '{default: '0};
   bit                 recur_tab  [SLOT_COUNT];
   bit                 held_tab   [SLOT_COUNT];
   bit                 armed_tab  [SLOT_COUNT];

   sched_rsp_type expected_q [$];
   int         error_count    = 0;
   int         burst_left     = 0;
   int         rx_hold_cycles = 0;
   bit         pace_requests  = 1'b1;
   bit         rx_steady      = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic sched_rsp_type advance_schedule(input sched_req_type r);
      sched_rsp_type      res;
      logic [NOW_W:0]     sum;
      logic [FIELD_W-1:0] sep;
      res.fire_mask = '0;
      if (r.func == FUNC_TICK) begin
         sum = clock_now + tick_len_cfg;
         clock_now = sum[NOW_W] ? '1 : sum[NOW_W-1:0];
         for (int i = 0; i < SLOT_COUNT; i++) begin
            if (armed_tab[i]) begin
               sep = (clock_now >= alarm_tab[i]) ? clock_now - alarm_tab[i]
                                                 : alarm_tab[i] - clock_now;
               if (!held_tab[i] && sep < window_cfg) begin
                  held_tab[i] = 1'b1;
                  res.fire_mask[i] = 1'b1;
                  if (recur_tab[i]) begin
                     sum = alarm_tab[i] + period_tab[i];
                     alarm_tab[i] = sum[FIELD_W] ? '1 : sum[FIELD_W-1:0];
                  end
               end else if (held_tab[i] && sep > window_cfg) begin
                  held_tab[i] = 1'b0;
               end
            end
         end
      end else begin
         alarm_tab[r.slot]  = r.alarm_time;
         period_tab[r.slot] = r.period;
         recur_tab[r.slot]  = r.repeat_req;
         held_tab[r.slot]   = 1'b0;
         armed_tab[r.slot]  = 1'b1;
      end
      res.now = clock_now;
      return res;
   endfunction

   function automatic sched_req_type tick_request();
      sched_req_type r;
      r.func       = FUNC_TICK;
      r.slot       = SLOT_W'($urandom_range(0, 7));
      r.alarm_time = $urandom;
      r.period     = $urandom;
      r.repeat_req = 1'($urandom_range(0, 1));
      return r;
   endfunction

   function automatic sched_req_type load_request(input logic [SLOT_W-1:0] slot,
                                                  input logic [FIELD_W-1:0] alarm,
                                                  input logic [FIELD_W-1:0] period,
                                                  input logic rep);
      sched_req_type r;
      r.func       = FUNC_LOAD;
      r.slot       = slot;
      r.alarm_time = alarm;
      r.period     = period;
      r.repeat_req = rep;
      return r;
   endfunction

   function automatic sched_req_type random_request();
      sched_req_type r;
      longint     t;
      r = tick_request();
      if ($urandom_range(0, 99) >= 68) begin
         r.func = FUNC_LOAD;
         if ($urandom_range(0, 4) != 0) begin
            t = longint'(clock_now) + longint'(tick_len_cfg) * longint'($urandom_range(0, 6))
                + longint'($urandom_range(0, 2 * window_cfg + 4)) - longint'(window_cfg) - 2;
            r.alarm_time = (t < 0) ? '0 : (t > longint'(32'hFFFF_FFFF)) ? '1 : t[31:0];
            case ($urandom_range(0, 9))
               0: r.period = '0;
               1: r.period = '1;
               2: r.period = $urandom;
               default: r.period = FIELD_W'(longint'(tick_len_cfg)
                                            * longint'($urandom_range(1, 8))
                                            + longint'($urandom_range(0, window_cfg)));
            endcase
         end
      end
      return r;
   endfunction

   task automatic send_request(input sched_req_type r);
      int gap;
      if (pace_requests) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
               req_bus.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
      end
      req_bus.valid      <= 1'b1;
      req_bus.func       <= r.func;
      req_bus.slot       <= r.slot;
      req_bus.alarm_time <= r.alarm_time;
      req_bus.period     <= r.period;
      req_bus.repeat_req <= r.repeat_req;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      expected_q.push_back(advance_schedule(r));
   endtask

   task automatic drain_responses;
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (expected_q.size() != 0);
   endtask

   task automatic write_settings(input logic [CFG_W-1:0] tick_len,
                                 input logic [CFG_W-1:0] window);
      csr_we    <= 1'b1;
      csr_index <= CSR_TICK_LEN;
      csr_wdata <= tick_len;
      @(posedge clock);
      tick_len_cfg = tick_len;
      csr_index <= CSR_WINDOW;
      csr_wdata <= window;
      @(posedge clock);
      window_cfg = window;
      csr_we <= 1'b0;
   endtask

   task automatic flag_mismatch(input string what, input logic [NOW_W-1:0] want,
                                input logic [NOW_W-1:0] got);
      error_count++;
      if (error_count <= 10)
         $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
   endtask

   task automatic test_reset_state;
      send_request(tick_request());
      send_request(load_request(3'd0, 32'd30, '0, 1'b0));
   endtask

   task automatic test_window_edges;
      // sit on the window edge, fire, hold at the edge, release
      repeat (4) send_request(tick_request());
      send_request(load_request(3'd7, '1, '1, 1'b1));
      send_request(load_request(3'd3, 32'd65, 32'd10, 1'b1));
      send_request(tick_request());
      send_request(tick_request());
      // reload clears the suspended flag
      send_request(load_request(3'd3, 32'd75, 32'd10, 1'b1));
      send_request(tick_request());
      // alarm advance saturates
      send_request(load_request(3'd4, 32'd95, 32'hFFFF_FFF0, 1'b1));
      send_request(tick_request());
      send_request(load_request(3'd2, '0, '0, 1'b0));
      send_request(tick_request());
   endtask

   task automatic test_window_zero;
      drain_responses();
      write_settings(TICK_LEN_RESET, '0);
      send_request(load_request(3'd1, clock_now + 32'd10, '0, 1'b0));
      send_request(tick_request());
      send_request(tick_request());
      drain_responses();
      write_settings(TICK_LEN_RESET, WINDOW_RESET);
   endtask

   task automatic test_random_traffic(input int per_setting);
      logic [CFG_W-1:0] tick_set [6] = '{16'd10, 16'd1, 16'd1, 16'hFFFF, 16'hFFFF, 16'd7};
      logic [CFG_W-1:0] win_set  [6] = '{16'd10, 16'd0, 16'hFFFF, 16'hFFFF, 16'd1, 16'd3};
      tick_set[5] = CFG_W'($urandom_range(1, 65535));
      win_set[5]  = CFG_W'($urandom_range(0, 65535));
      for (int p = 0; p < 6; p++) begin
         drain_responses();
         write_settings(tick_set[p], win_set[p]);
         repeat (per_setting) send_request(random_request());
      end
   endtask

   task automatic test_output_stall;
      pace_requests  = 1'b0;
      rx_hold_cycles = 300;
      repeat (16) send_request(random_request());
      drain_responses();
      pace_requests = 1'b1;
   endtask

   task automatic test_large_ticks;
      drain_responses();
      write_settings(16'hFFFF, 16'hFFFF);
      pace_requests = 1'b0;
      rx_steady     = 1'b1;
      send_request(load_request(3'd5, 32'hFFFE_0000, '1, 1'b1));
      send_request(load_request(3'd6, '1, '0, 1'b0));
      send_request(load_request(3'd2, 32'hFFFC_FFFC, 32'd65535, 1'b1));
      repeat (20) send_request(tick_request());
      drain_responses();
      pace_requests = 1'b1;
      rx_steady     = 1'b0;
   endtask

   initial begin : response_sink
      int hold_left;
      int mode;
      int mode_left;
      rsp_bus.ready <= 1'b0;
      mode      = 0;
      mode_left = 0;
      forever begin
         @(posedge clock);
         if (rx_hold_cycles > 0) begin
            hold_left      = rx_hold_cycles;
            rx_hold_cycles = 0;
            rsp_bus.ready <= 1'b0;
            repeat (hold_left) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else if (rx_steady) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            case (mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= 1'($urandom_range(0, 1));
               2: rsp_bus.ready <= (mode_left % 5) >= 2;
               default: rsp_bus.ready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   initial begin : response_check
      sched_rsp_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (expected_q.size() == 0) begin
               flag_mismatch("unexpected response, now", 'x, rsp_bus.now);
            end else begin
               want = expected_q.pop_front();
               if (rsp_bus.fire_mask !== want.fire_mask)
                  flag_mismatch("fire_mask", NOW_W'(want.fire_mask),
                                NOW_W'(rsp_bus.fire_mask));
               if (rsp_bus.now !== want.now)
                  flag_mismatch("now", want.now, rsp_bus.now);
            end
         end
      end
   end

   initial begin : watchdog
      int stalled;
      stalled = 0;
      while (stalled < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
            stalled = 0;
         else
            stalled++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : test_sequence
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.func       <= FUNC_TICK;
      req_bus.slot       <= '0;
      req_bus.alarm_time <= '0;
      req_bus.period     <= '0;
      req_bus.repeat_req <= 1'b0;
      csr_we             <= 1'b0;
      csr_index          <= CSR_TICK_LEN;
      csr_wdata          <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_window_edges();
      test_window_zero();
      test_random_traffic(272);
      test_output_stall();
      test_large_ticks();

      drain_responses();
      repeat (24) @(posedge clock);
      error_count += expected_q.size();
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
